/* sv/ring_neighbor_exclusion_arbiter_top_defines.svh */
// assertion macros shared by the arbiter rtl
`ifndef RING_NEIGHBOR_EXCLUSION_ARBITER_TOP_DEFINES_SVH
`define RING_NEIGHBOR_EXCLUSION_ARBITER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RNEA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rnea assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define RNEA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rnea assertion failed");

`endif

/* sv/rnea_pkg.sv */
// shared types and constants of the ring neighbor exclusion arbiter
package rnea_pkg;

  localparam int RNEA_MAX_CLIENTS_DEF = 16;

  localparam int ID_W    = 5;
  localparam int RUNS_W  = 16;
  localparam int COUNT_W = 20;
  localparam int PROD_W  = RUNS_W + ID_W;

  localparam logic [COUNT_W-1:0] RUNS_MAX = {COUNT_W{1'b1}};

  // operation codes
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIENT_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RUNS_PER_CLIENT = 1'd1;
  localparam int CFG_DATA_W = RUNS_W;

  typedef enum logic [1:0] {
    PH_THINK  = 2'd0,
    PH_HUNGRY = 2'd1,
    PH_EAT    = 2'd2
  } phase_t;

  // ring neighbors of one client id
  typedef struct packed {
    logic [ID_W-1:0] left_id;
    logic [ID_W-1:0] right_id;
  } rnea_nbr_t;

endpackage

/* sv/rnea_if.sv */
// valid/ready channel interfaces for events and grant results
interface rnea_in_if import rnea_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            operation;
  logic [ID_W-1:0] client_id;

  modport source (output valid, output operation, output client_id, input ready);
  modport sink   (input valid, input operation, input client_id, output ready);
endinterface

interface rnea_out_if import rnea_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            grant_first_valid;
  logic [ID_W-1:0] grant_first_id;
  logic            grant_second_valid;
  logic [ID_W-1:0] grant_second_id;
  logic            all_done;
  logic            bad_event;

  modport source (output valid, output grant_first_valid, output grant_first_id,
                  output grant_second_valid, output grant_second_id,
                  output all_done, output bad_event, input ready);
  modport sink   (input valid, input grant_first_valid, input grant_first_id,
                  input grant_second_valid, input grant_second_id,
                  input all_done, input bad_event, output ready);
endinterface

/* sv/rnea_phase_mem.sv */
// client phase memory: one write port, one registered read port, per-entry valid bits
module rnea_phase_mem import rnea_pkg::*; #(
  parameter int DEPTH = RNEA_MAX_CLIENTS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  phase_t        wdata,
  input  logic [AW-1:0] raddr,
  output phase_t        rdata
);

  phase_t             mem [DEPTH];
  logic [DEPTH-1:0]   valid_r;
  phase_t             rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // an entry never written since reset reads as thinking
  always_ff @(posedge clk) begin
    rdata_r <= valid_r[raddr] ? mem[raddr] : PH_THINK;
  end

  assign rdata = rdata_r;

endmodule

/* sv/rnea_ring_unit.sv */
// shared ring addressing unit: left and right neighbor of one id on a ring of n
module rnea_ring_unit import rnea_pkg::*; (
  input  logic [ID_W-1:0] id,
  input  logic [ID_W-1:0] ring_n,
  output rnea_nbr_t       nbr
);

  assign nbr.left_id  = (id == ID_W'(1)) ? ring_n : id - ID_W'(1);
  assign nbr.right_id = (id == ring_n) ? ID_W'(1) : id + ID_W'(1);

endmodule

/* sv/ring_neighbor_exclusion_arbiter_top.sv */
// ring neighbor exclusion arbiter: sequencer, config registers and result register
// a request marks the client hungry, then walks the single phase memory read port over
// target, left and right neighbor; a release marks the client thinking, then walks the
// same read port over target, left and right neighbor for each of the two grant checks
// a bad or post-done event goes straight to the result; a stalled result holds the sequencer
// synchronous reset clears all phases to thinking at once, counts to zero, config to 5 and 1
module ring_neighbor_exclusion_arbiter_top import rnea_pkg::*; #(
  parameter int MAX_CLIENTS = RNEA_MAX_CLIENTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rnea_in_if.sink               in_ch,
  rnea_out_if.source            out_ch
);

`include "ring_neighbor_exclusion_arbiter_top_defines.svh"

  localparam int AW = $clog2(MAX_CLIENTS);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_WR   = 7'b0000010,
    S_RDS  = 7'b0000100,
    S_RDL  = 7'b0001000,
    S_RDR  = 7'b0010000,
    S_EVAL = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ID_W-1:0]     client_count_r;
  logic [RUNS_W-1:0]   runs_r;
  logic                op_r, op_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [ID_W-1:0]     n_r, n_nxt;
  logic [ID_W-1:0]     target_r, target_nxt;
  logic                slot_r, slot_nxt;
  logic                self_ok_r, self_ok_nxt;
  logic                left_ok_r, left_ok_nxt;
  logic                g1v_r, g1v_nxt;
  logic [ID_W-1:0]     g1_r, g1_nxt;
  logic                g2v_r, g2v_nxt;
  logic [ID_W-1:0]     g2_r, g2_nxt;
  logic                bad_r, bad_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [COUNT_W-1:0]  completed_r, completed_nxt;
  logic                finished_r, finished_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_g1v_r, out_g1v_nxt;
  logic [ID_W-1:0]     out_g1_r, out_g1_nxt;
  logic                out_g2v_r, out_g2v_nxt;
  logic [ID_W-1:0]     out_g2_r, out_g2_nxt;
  logic                out_done_r, out_done_nxt;
  logic                out_bad_r, out_bad_nxt;

  logic [ID_W-1:0]     n_eff;
  logic                in_bad;
  logic [ID_W-1:0]     ring_id;
  rnea_nbr_t           nbr;
  logic [ID_W-1:0]     rd_id;
  logic [ID_W-1:0]     wr_id;
  logic [ID_W-1:0]     rd_idm1;
  logic [ID_W-1:0]     wr_idm1;
  logic                mem_we;
  phase_t              mem_wdata;
  phase_t              mem_rdata;
  logic                grant_ok;
  logic                done_hit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      client_count_r <= ID_W'(5);
      runs_r         <= RUNS_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLIENT_COUNT:    client_count_r <= cfg_data[ID_W-1:0];
        REG_RUNS_PER_CLIENT: runs_r         <= cfg_data[RUNS_W-1:0];
        default: ;
      endcase
    end
  end

  // ring size saturated to 1..MAX_CLIENTS
  always_comb begin
    if (client_count_r == '0) begin
      n_eff = ID_W'(1);
    end else if (int'(client_count_r) > MAX_CLIENTS) begin
      n_eff = ID_W'(MAX_CLIENTS);
    end else begin
      n_eff = client_count_r;
    end
  end

  assign in_bad = finished_r || (in_ch.client_id == '0) || (in_ch.client_id > n_eff);

  // one ring unit, shared between the event id and the client under test
  assign ring_id = ((state_r == S_WR) || (state_r == S_EVAL)) ? id_r : target_r;

  rnea_ring_unit u_ring (
    .id     (ring_id),
    .ring_n (n_r),
    .nbr    (nbr)
  );

  always_comb begin
    case (state_r)
      S_RDL:   rd_id = nbr.left_id;
      S_RDR:   rd_id = nbr.right_id;
      default: rd_id = target_r;
    endcase
  end

  assign grant_ok  = self_ok_r && left_ok_r && (mem_rdata != PH_EAT);
  assign mem_we    = (state_r == S_WR) || ((state_r == S_EVAL) && grant_ok);
  assign wr_id     = (state_r == S_WR) ? id_r : target_r;
  assign mem_wdata = (state_r == S_WR) ? ((op_r == OP_RELEASE) ? PH_THINK : PH_HUNGRY)
                                       : PH_EAT;
  assign rd_idm1   = rd_id - ID_W'(1);
  assign wr_idm1   = wr_id - ID_W'(1);

  rnea_phase_mem #(
    .DEPTH (MAX_CLIENTS),
    .AW    (AW)
  ) u_phase_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (AW'(wr_idm1)),
    .wdata (mem_wdata),
    .raddr (AW'(rd_idm1)),
    .rdata (mem_rdata)
  );

  assign done_hit = {1'b0, completed_r} >= prod_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    n_nxt         = n_r;
    target_nxt    = target_r;
    slot_nxt      = slot_r;
    self_ok_nxt   = self_ok_r;
    left_ok_nxt   = left_ok_r;
    g1v_nxt       = g1v_r;
    g1_nxt        = g1_r;
    g2v_nxt       = g2v_r;
    g2_nxt        = g2_r;
    bad_nxt       = bad_r;
    prod_nxt      = prod_r;
    completed_nxt = completed_r;
    finished_nxt  = finished_r;
    out_valid_nxt = out_valid_r;
    out_g1v_nxt   = out_g1v_r;
    out_g1_nxt    = out_g1_r;
    out_g2v_nxt   = out_g2v_r;
    out_g2_nxt    = out_g2_r;
    out_done_nxt  = out_done_r;
    out_bad_nxt   = out_bad_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = in_ch.operation;
          id_nxt    = in_ch.client_id;
          n_nxt     = n_eff;
          prod_nxt  = {{ID_W{1'b0}}, runs_r} * {{RUNS_W{1'b0}}, n_eff};
          bad_nxt   = in_bad;
          slot_nxt  = 1'b0;
          g1v_nxt   = 1'b0;
          g1_nxt    = '0;
          g2v_nxt   = 1'b0;
          g2_nxt    = '0;
          state_nxt = in_bad ? S_FIN : S_WR;
        end
      end
      S_WR: begin
        if (op_r == OP_RELEASE) begin
          if (completed_r != RUNS_MAX) begin
            completed_nxt = completed_r + COUNT_W'(1);
          end
          target_nxt = nbr.left_id;
        end else begin
          target_nxt = id_r;
        end
        state_nxt = S_RDS;
      end
      S_RDS: begin
        state_nxt = S_RDL;
      end
      S_RDL: begin
        self_ok_nxt = (mem_rdata == PH_HUNGRY);
        state_nxt   = S_RDR;
      end
      S_RDR: begin
        left_ok_nxt = (mem_rdata != PH_EAT);
        state_nxt   = S_EVAL;
      end
      S_EVAL: begin
        if (grant_ok) begin
          if (!slot_r) begin
            g1v_nxt = 1'b1;
            g1_nxt  = target_r;
          end else begin
            g2v_nxt = 1'b1;
            g2_nxt  = target_r;
          end
        end
        // release checks the right neighbor after the left one
        if ((op_r == OP_RELEASE) && !slot_r) begin
          slot_nxt   = 1'b1;
          target_nxt = nbr.right_id;
          state_nxt  = S_RDS;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          finished_nxt  = finished_r || done_hit;
          out_valid_nxt = 1'b1;
          out_g1v_nxt   = g1v_r;
          out_g1_nxt    = g1_r;
          out_g2v_nxt   = g2v_r;
          out_g2_nxt    = g2_r;
          out_done_nxt  = finished_r || done_hit;
          out_bad_nxt   = bad_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      completed_r <= '0;
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      completed_r <= completed_nxt;
      finished_r  <= finished_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    n_r        <= n_nxt;
    target_r   <= target_nxt;
    slot_r     <= slot_nxt;
    self_ok_r  <= self_ok_nxt;
    left_ok_r  <= left_ok_nxt;
    g1v_r      <= g1v_nxt;
    g1_r       <= g1_nxt;
    g2v_r      <= g2v_nxt;
    g2_r       <= g2_nxt;
    bad_r      <= bad_nxt;
    prod_r     <= prod_nxt;
    out_g1v_r  <= out_g1v_nxt;
    out_g1_r   <= out_g1_nxt;
    out_g2v_r  <= out_g2v_nxt;
    out_g2_r   <= out_g2_nxt;
    out_done_r <= out_done_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  assign in_ch.ready               = rst_n && (state_r == S_IDLE);
  assign out_ch.valid              = out_valid_r;
  assign out_ch.grant_first_valid  = out_g1v_r;
  assign out_ch.grant_first_id     = out_g1_r;
  assign out_ch.grant_second_valid = out_g2v_r;
  assign out_ch.grant_second_id    = out_g2_r;
  assign out_ch.all_done           = out_done_r;
  assign out_ch.bad_event          = out_bad_r;

  `RNEA_ASSERT_NEXT(a_done_sticky, finished_r, finished_r)
  `RNEA_ASSERT_NEXT(a_runs_monotonic, 1'b1, completed_r >= $past(completed_r))
  `RNEA_ASSERT_NOW(a_bad_no_grant, out_valid_r && out_bad_r, !out_g1v_r && !out_g2v_r)
  `RNEA_ASSERT_NOW(a_no_double_grant, out_valid_r && out_g1v_r && out_g2v_r,
    out_g1_r != out_g2_r)

endmodule

/* sim/ring_neighbor_exclusion_arbiter_top_tb.sv */
// testbench of the ring neighbor exclusion arbiter with a grant predictor
module ring_neighbor_exclusion_arbiter_top_tb import rnea_pkg::*; ();

  localparam int MAXC          = RNEA_MAX_CLIENTS_DEF;
  localparam int SETTLE_CYCLES = 14;
  localparam int CYCLE_LIMIT   = 300000;

  typedef struct packed {
    logic            first_valid;
    logic [ID_W-1:0] first_id;
    logic            second_valid;
    logic [ID_W-1:0] second_id;
    logic            done;
    logic            bad;
  } grant_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rnea_in_if  in_ch ();
  rnea_out_if out_ch ();

  ring_neighbor_exclusion_arbiter_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // predictor state
  phase_t             phase_tbl [MAXC];
  logic [COUNT_W-1:0] runs_done;
  logic               finished_q;
  logic [ID_W-1:0]    ring_cfg;
  logic [RUNS_W-1:0]  runs_cfg;

  grant_result_t grants_due [$];
  int            err_count;
  int            cycle_count;
  int            hold_off_left;
  bit            idle_on;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL ring_neighbor_exclusion_arbiter_top");
      $finish;
    end
  end

  function automatic int ring_n();
    if (ring_cfg < 1) return 1;
    if (ring_cfg > MAXC) return MAXC;
    return int'(ring_cfg);
  endfunction

  function automatic int left_of(int id, int n);
    return (id == 1) ? n : id - 1;
  endfunction

  function automatic int right_of(int id, int n);
    return (id == n) ? 1 : id + 1;
  endfunction

  function automatic bit neighbors_free(int id, int n);
    return phase_tbl[left_of(id, n) - 1] != PH_EAT && phase_tbl[right_of(id, n) - 1] != PH_EAT;
  endfunction

  function automatic bit seat_if_hungry(int id, int n);
    if (phase_tbl[id - 1] == PH_HUNGRY && neighbors_free(id, n)) begin
      phase_tbl[id - 1] = PH_EAT;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // next grant result for one event, updating the phase table and run count
  function automatic grant_result_t arbitrate(logic op, logic [ID_W-1:0] cid);
    grant_result_t res;
    int n;
    int id;
    int lt;
    int rt;
    res = '0;
    n = ring_n();
    id = int'(cid);
    if (finished_q || id < 1 || id > n) begin
      res.bad = 1'b1;
    end else if (op == OP_REQUEST) begin
      phase_tbl[id - 1] = PH_HUNGRY;
      if (neighbors_free(id, n)) begin
        phase_tbl[id - 1] = PH_EAT;
        res.first_valid = 1'b1;
        res.first_id = ID_W'(id);
      end
    end else begin
      lt = left_of(id, n);
      rt = right_of(id, n);
      phase_tbl[id - 1] = PH_THINK;
      if (runs_done != RUNS_MAX) runs_done++;
      // right check sees the left grant
      if (seat_if_hungry(lt, n)) begin
        res.first_valid = 1'b1;
        res.first_id = ID_W'(lt);
      end
      if (seat_if_hungry(rt, n)) begin
        res.second_valid = 1'b1;
        res.second_id = ID_W'(rt);
      end
    end
    if (!finished_q && int'(runs_done) >= int'(runs_cfg) * n) finished_q = 1'b1;
    res.done = finished_q;
    return res;
  endfunction

  // mostly legal ids; releases lean toward clients that are eating
  function automatic logic [ID_W-1:0] pick_client(logic op);
    int n;
    int r;
    int start;
    n = ring_n();
    r = $urandom_range(0, 99);
    if (r < 8) begin
      if ($urandom_range(0, 1) == 0) return '0;
      return ID_W'($urandom_range(n + 1, 31));
    end
    if (op == OP_RELEASE && r < 70) begin
      start = $urandom_range(0, n - 1);
      for (int k = 0; k < n; k++) begin
        if (phase_tbl[(start + k) % n] == PH_EAT) return ID_W'((start + k) % n + 1);
      end
    end
    return ID_W'($urandom_range(1, n));
  endfunction

  function automatic void check_field(string fname, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", fname, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    grant_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (grants_due.size() == 0) begin
        $error("result transfer with no event outstanding");
        err_count++;
      end else begin
        want = grants_due.pop_front();
        check_field("grant_first_valid", int'(want.first_valid),
                    int'(out_ch.grant_first_valid));
        check_field("grant_first_id", int'(want.first_id), int'(out_ch.grant_first_id));
        check_field("grant_second_valid", int'(want.second_valid),
                    int'(out_ch.grant_second_valid));
        check_field("grant_second_id", int'(want.second_id), int'(out_ch.grant_second_id));
        check_field("all_done", int'(want.done), int'(out_ch.all_done));
        check_field("bad_event", int'(want.bad), int'(out_ch.bad_event));
      end
    end
  end

  // result side: long hold-off on request, else random stall bursts while idle_on is set
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_ch.ready = 1'b0;
        hold_off_left--;
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        stall_left = $urandom_range(1, 9) - 1;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  task automatic send_event(logic op, logic [ID_W-1:0] cid);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.operation = op;
    in_ch.client_id = cid;
    do @(posedge clk); while (!in_ch.ready);
    grants_due.push_back(arbitrate(op, cid));
    @(negedge clk);
  endtask

  task automatic send_random();
    logic op;
    op = ($urandom_range(0, 99) < 45) ? OP_REQUEST : OP_RELEASE;
    send_event(op, pick_client(op));
  endtask

  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (grants_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    if (idx == REG_CLIENT_COUNT) ring_cfg = data[ID_W-1:0];
    else runs_cfg = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic test_basic_grants();
    // ring of five at reset size
    send_event(OP_REQUEST, 5'd1);
    send_event(OP_REQUEST, 5'd2);
    send_event(OP_REQUEST, 5'd5);
    send_event(OP_REQUEST, 5'd3);
    send_event(OP_RELEASE, 5'd1);
    send_event(OP_RELEASE, 5'd4);
    send_event(OP_REQUEST, 5'd3);
    send_event(OP_RELEASE, 5'd3);
    send_event(OP_RELEASE, 5'd5);
    send_event(OP_REQUEST, 5'd0);
    send_event(OP_RELEASE, 5'd6);
    send_event(OP_REQUEST, 5'd31);
    send_event(OP_RELEASE, 5'd16);
  endtask

  task automatic test_small_rings();
    write_reg(REG_CLIENT_COUNT, 16'd1);
    send_event(OP_REQUEST, 5'd1);
    send_event(OP_REQUEST, 5'd1);
    send_event(OP_RELEASE, 5'd1);
    send_event(OP_REQUEST, 5'd2);
    write_reg(REG_CLIENT_COUNT, 16'd2);
    send_event(OP_REQUEST, 5'd1);
    send_event(OP_REQUEST, 5'd2);
    send_event(OP_RELEASE, 5'd1);
    send_event(OP_RELEASE, 5'd2);
    // zero acts as a ring of one
    write_reg(REG_CLIENT_COUNT, 16'd0);
    send_event(OP_REQUEST, 5'd1);
    send_event(OP_RELEASE, 5'd1);
    // above the maximum saturates to sixteen
    write_reg(REG_CLIENT_COUNT, 16'd31);
    send_event(OP_REQUEST, 5'd16);
    send_event(OP_REQUEST, 5'd17);
  endtask

  task automatic test_random_traffic(logic [CFG_DATA_W-1:0] ring, logic [CFG_DATA_W-1:0] runs,
                                     int count);
    write_reg(REG_CLIENT_COUNT, ring);
    write_reg(REG_RUNS_PER_CLIENT, runs);
    for (int i = 0; i < count; i++) begin
      // some stretches run with no idling at all
      if (i % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
      send_random();
    end
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    hold_off_left = 150;
    for (int i = 0; i < 12; i++) send_random();
    wait_idle();
  endtask

  task automatic test_sender_pause();
    for (int i = 0; i < 10; i++) send_random();
    in_ch.valid = 1'b0;
    while (grants_due.size() != 0) @(negedge clk);
    for (int i = 0; i < 10; i++) send_random();
  endtask

  task automatic test_final_burst();
    idle_on = 1'b0;
    for (int i = 0; i < 50; i++) send_random();
  endtask

  task automatic test_finish();
    // zero runs per client: the next event, even a bad one, finishes the block
    write_reg(REG_RUNS_PER_CLIENT, 16'd0);
    send_event(OP_REQUEST, 5'd0);
    send_event(OP_REQUEST, 5'd1);
    send_event(OP_RELEASE, 5'd1);
    send_event(OP_RELEASE, 5'd31);
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_REQUEST;
    in_ch.client_id = '0;
    err_count = 0;
    cycle_count = 0;
    hold_off_left = 0;
    idle_on = 1'b1;
    for (int i = 0; i < MAXC; i++) phase_tbl[i] = PH_THINK;
    runs_done = '0;
    finished_q = 1'b0;
    ring_cfg = 5'd5;
    runs_cfg = 16'd1;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    write_reg(REG_RUNS_PER_CLIENT, 16'hFFFF);
    test_basic_grants();
    test_small_rings();
    test_random_traffic(16'd16, 16'hFFFF, 110);
    test_random_traffic(16'd3, 16'd1000, 110);
    test_random_traffic(16'd31, CFG_DATA_W'($urandom_range(2000, 65535)), 110);
    test_random_traffic(16'd7, 16'd40000, 110);
    test_random_traffic(CFG_DATA_W'($urandom_range(1, 16)), 16'hFFFF, 110);
    test_backpressure();
    test_sender_pause();
    test_final_burst();
    test_finish();

    wait_idle();
    if (grants_due.size() != 0) begin
      $error("%0d results never arrived", grants_due.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("PASS ring_neighbor_exclusion_arbiter_top");
    end else begin
      $display("FAIL ring_neighbor_exclusion_arbiter_top");
    end
    $finish;
  end

endmodule
